@@ rtl/bmrs_pkg.sv @@
package bmrs_pkg;

  localparam int KIND_W = 3;
  localparam int POS_W  = 10;
  localparam int SIZE_W = 11;

  localparam logic [KIND_W-1:0] KIND_TEST      = 3'd0;
  localparam logic [KIND_W-1:0] KIND_SET       = 3'd1;
  localparam logic [KIND_W-1:0] KIND_CLEAR     = 3'd2;
  localparam logic [KIND_W-1:0] KIND_RANGE_SET = 3'd3;
  localparam logic [KIND_W-1:0] KIND_RANGE_CLR = 3'd4;
  localparam logic [KIND_W-1:0] KIND_FILL_GAPS = 3'd5;
  localparam logic [KIND_W-1:0] KIND_INVERT    = 3'd6;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [POS_W-1:0]  position;
    logic [POS_W-1:0]  range_end;
  } in_t;

  typedef struct packed {
    logic              bit_value;
    logic [POS_W-1:0]  first_set;
    logic [POS_W-1:0]  first_clear;
    logic              any_clear;
    logic [POS_W-1:0]  last_set;
    logic              any_set;
    logic [SIZE_W-1:0] set_count;
    logic              bad_position;
  } out_t;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_SET,
    OP_CLR,
    OP_INV
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_SCAN,
    ST_UPDATE
  } state_t;

endpackage

@@ rtl/bitmap_range_search_engine.sv @@
// Bitmap range search engine.
// Command channel: present in_data with start; the command is taken at a clock
// edge where start is high and busy is low. busy stays high while it runs.
// Result channel: out_valid pulses for one cycle with out_data; the receiver
// must take it then, there is no back-pressure.
// Config channel: cfg_data is the map size, written when cfg_valid and
// cfg_ready are both high. cfg_ready is only high while idle and start is low.
// A size write trims all bits at or above the new size in a sweep over every
// word of the map (busy meanwhile).
// Sweeps (NWORDS = ceil(MAP_BITS/WORD_BITS), 32 by default):
//   a command sweeps the map once, one word per cycle through the single
//   memory read port, plus one pipeline stage; the next command can be
//   taken at the same edge at which the result is taken.
//   Fill gaps sweeps twice per command (scan, then update).
// Reset: synchronous, active low; afterwards a clearing sweep zeroes the
// map with busy high. Size resets to MAP_BITS.
module bitmap_range_search_engine #(
  parameter int MAP_BITS  = 1024,
  parameter int WORD_BITS = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  bmrs_pkg::in_t               in_data,
  output logic                        out_valid,
  output bmrs_pkg::out_t              out_data,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [bmrs_pkg::SIZE_W-1:0] cfg_data
);

  localparam int NWORDS = (MAP_BITS + WORD_BITS - 1) / WORD_BITS;
  localparam int IDX_W0 = $clog2(NWORDS * WORD_BITS + 1);
  localparam int IDX_W  = (IDX_W0 > bmrs_pkg::SIZE_W) ? IDX_W0 : bmrs_pkg::SIZE_W;
  localparam int AW     = (NWORDS > 1) ? $clog2(NWORDS) : 1;
  localparam int CNT_W  = $clog2(NWORDS + 1);
  localparam int OFF_W  = $clog2(WORD_BITS);
  localparam int POP_P  = 2 ** $clog2(WORD_BITS);
  localparam int PCW    = $clog2(WORD_BITS + 1);
  localparam logic [bmrs_pkg::SIZE_W-1:0] RST_SIZE = bmrs_pkg::SIZE_W'(MAP_BITS);

  function automatic logic [IDX_W-1:0] eff_size(input logic [bmrs_pkg::SIZE_W-1:0] v);
    logic [IDX_W-1:0] e;
    e = IDX_W'(v);
    return (e > IDX_W'(MAP_BITS)) ? IDX_W'(MAP_BITS) : e;
  endfunction

  bmrs_pkg::state_t state_r, state_nxt;

  logic [WORD_BITS-1:0] bitmap_mem [NWORDS];

  logic [CNT_W-1:0]     iss_cnt_r;
  logic [IDX_W-1:0]     iss_base_r;
  logic                 stg_vld_r;
  logic [AW-1:0]        stg_addr_r;
  logic [IDX_W-1:0]     stg_base_r;
  logic [WORD_BITS-1:0] rdata_r;
  logic                 out_valid_r;
  logic [IDX_W-1:0]     size_r;
  logic                 clr_all_r;

  bmrs_pkg::op_t        op_r;
  logic [IDX_W-1:0]     pos_r, lo_r, hi_r;
  logic                 bad_r;
  bmrs_pkg::out_t       out_r;

  logic                 any_set_r, any_clr_r, bitv_r;
  logic [IDX_W-1:0]     fs_r, ls_r, fc_r, cnt_r;
  logic                 any_set_nxt, any_clr_nxt, bitv_nxt;
  logic [IDX_W-1:0]     fs_nxt, ls_nxt, fc_nxt, cnt_nxt;

  logic sweep_go, acc_clr, cmd_take, cfg_take, out_load, scan_done;
  logic iss_en, sweep_last;

  logic [WORD_BITS-1:0] vmask, rmask, pmask;
  logic [WORD_BITS-1:0] new_word, wr_word, scan_word, clr_word;
  logic [OFF_W-1:0]     fs_off, ls_off, fc_off;
  logic                 set_hit, clr_hit;
  logic [POP_P-1:0]     pad_word;
  logic [PCW-1:0]       pop_lvl [POP_P];
  logic [PCW-1:0]       pop;

  logic [IDX_W-1:0]     in_pos, in_end;
  logic                 pos_bad, rng_bad;

  assign busy      = (state_r != bmrs_pkg::ST_IDLE);
  assign cfg_ready = !busy && !start;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign iss_en = (state_r != bmrs_pkg::ST_IDLE) && (iss_cnt_r != CNT_W'(NWORDS));
  assign sweep_last = stg_vld_r && !iss_en;

  assign in_pos  = IDX_W'(in_data.position);
  assign in_end  = IDX_W'(in_data.range_end);
  assign pos_bad = in_pos >= size_r;
  assign rng_bad = pos_bad || (in_end >= size_r) || (in_end < in_pos);

  // sequencer
  always_comb begin
    state_nxt = state_r;
    sweep_go  = 1'b0;
    acc_clr   = 1'b0;
    cmd_take  = 1'b0;
    cfg_take  = 1'b0;
    out_load  = 1'b0;
    scan_done = 1'b0;
    case (state_r)
      bmrs_pkg::ST_IDLE: begin
        if (start) begin
          cmd_take = 1'b1;
          sweep_go = 1'b1;
          acc_clr  = 1'b1;
          state_nxt = (in_data.kind == bmrs_pkg::KIND_FILL_GAPS) ?
                      bmrs_pkg::ST_SCAN : bmrs_pkg::ST_UPDATE;
        end else if (cfg_valid) begin
          cfg_take  = 1'b1;
          sweep_go  = 1'b1;
          state_nxt = bmrs_pkg::ST_CLEAR;
        end
      end
      bmrs_pkg::ST_CLEAR: begin
        if (sweep_last) state_nxt = bmrs_pkg::ST_IDLE;
      end
      bmrs_pkg::ST_SCAN: begin
        if (sweep_last) begin
          scan_done = 1'b1;
          sweep_go  = 1'b1;
          acc_clr   = 1'b1;
          state_nxt = bmrs_pkg::ST_UPDATE;
        end
      end
      bmrs_pkg::ST_UPDATE: begin
        if (sweep_last) begin
          out_load  = 1'b1;
          state_nxt = bmrs_pkg::ST_IDLE;
        end
      end
      default: state_nxt = bmrs_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bmrs_pkg::ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // per-bit masks of the word in the stage
  always_comb begin
    for (int j = 0; j < WORD_BITS; j++) begin
      vmask[j] = (stg_base_r + IDX_W'(j)) < size_r;
      rmask[j] = ((stg_base_r + IDX_W'(j)) >= lo_r) && ((stg_base_r + IDX_W'(j)) <= hi_r);
      pmask[j] = (stg_base_r + IDX_W'(j)) == pos_r;
    end
  end

  always_comb begin
    case (op_r)
      bmrs_pkg::OP_SET:  new_word = rdata_r | rmask;
      bmrs_pkg::OP_CLR:  new_word = rdata_r & ~rmask;
      bmrs_pkg::OP_INV:  new_word = rdata_r ^ vmask;
      default:           new_word = rdata_r;
    endcase
    if (state_r == bmrs_pkg::ST_CLEAR) begin
      wr_word = clr_all_r ? '0 : (rdata_r & vmask);
    end else begin
      wr_word = new_word;
    end
    scan_word = (state_r == bmrs_pkg::ST_SCAN) ? rdata_r : new_word;
    clr_word  = ~scan_word & vmask;
  end

  // word statistics
  always_comb begin
    fs_off = '0;
    ls_off = '0;
    fc_off = '0;
    for (int j = WORD_BITS - 1; j >= 0; j--) begin
      if (scan_word[j]) fs_off = OFF_W'(j);
      if (clr_word[j])  fc_off = OFF_W'(j);
    end
    for (int j = 0; j < WORD_BITS; j++) begin
      if (scan_word[j]) ls_off = OFF_W'(j);
    end
    set_hit = |scan_word;
    clr_hit = |clr_word;
  end

  always_comb begin
    pad_word = POP_P'(scan_word);
    for (int i = 0; i < POP_P; i++) begin
      pop_lvl[i] = PCW'(pad_word[i]);
    end
    for (int s = 1; s < POP_P; s = s * 2) begin
      for (int i = 0; i + s < POP_P; i = i + 2 * s) begin
        pop_lvl[i] = pop_lvl[i] + pop_lvl[i + s];
      end
    end
    pop = pop_lvl[0];
  end

  always_comb begin
    any_set_nxt = any_set_r | set_hit;
    fs_nxt      = (!any_set_r && set_hit) ? (stg_base_r + IDX_W'(fs_off)) : fs_r;
    ls_nxt      = set_hit ? (stg_base_r + IDX_W'(ls_off)) : ls_r;
    any_clr_nxt = any_clr_r | clr_hit;
    fc_nxt      = (!any_clr_r && clr_hit) ? (stg_base_r + IDX_W'(fc_off)) : fc_r;
    cnt_nxt     = cnt_r + IDX_W'(pop);
    bitv_nxt    = bitv_r | (|(scan_word & pmask & vmask));
  end

  // sweep control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iss_cnt_r   <= '0;
      iss_base_r  <= '0;
      stg_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
      size_r      <= eff_size(RST_SIZE);
      clr_all_r   <= 1'b1;
    end else begin
      stg_vld_r   <= iss_en;
      out_valid_r <= out_load;
      if (sweep_go) begin
        iss_cnt_r  <= '0;
        iss_base_r <= '0;
      end else if (iss_en) begin
        iss_cnt_r  <= iss_cnt_r + CNT_W'(1);
        iss_base_r <= iss_base_r + IDX_W'(WORD_BITS);
      end
      if (cfg_take) begin
        size_r    <= eff_size(cfg_data);
        clr_all_r <= 1'b0;
      end
    end
  end

  // map storage
  always_ff @(posedge clk) begin
    if (stg_vld_r && (state_r == bmrs_pkg::ST_CLEAR || state_r == bmrs_pkg::ST_UPDATE)) begin
      bitmap_mem[stg_addr_r] <= wr_word;
    end
    if (iss_en) begin
      rdata_r <= bitmap_mem[iss_cnt_r[AW-1:0]];
    end
    stg_addr_r <= iss_cnt_r[AW-1:0];
    stg_base_r <= iss_base_r;
  end

  // command and result datapath
  always_ff @(posedge clk) begin
    if (cmd_take) begin
      pos_r <= in_pos;
      lo_r  <= in_pos;
      hi_r  <= in_pos;
      bad_r <= 1'b0;
      op_r  <= bmrs_pkg::OP_NONE;
      case (in_data.kind)
        bmrs_pkg::KIND_TEST: begin
          bad_r <= pos_bad;
        end
        bmrs_pkg::KIND_SET: begin
          bad_r <= pos_bad;
          op_r  <= pos_bad ? bmrs_pkg::OP_NONE : bmrs_pkg::OP_SET;
        end
        bmrs_pkg::KIND_CLEAR: begin
          bad_r <= pos_bad;
          op_r  <= pos_bad ? bmrs_pkg::OP_NONE : bmrs_pkg::OP_CLR;
        end
        bmrs_pkg::KIND_RANGE_SET: begin
          hi_r  <= in_end;
          bad_r <= rng_bad;
          op_r  <= rng_bad ? bmrs_pkg::OP_NONE : bmrs_pkg::OP_SET;
        end
        bmrs_pkg::KIND_RANGE_CLR: begin
          hi_r  <= in_end;
          bad_r <= rng_bad;
          op_r  <= rng_bad ? bmrs_pkg::OP_NONE : bmrs_pkg::OP_CLR;
        end
        bmrs_pkg::KIND_INVERT: begin
          op_r <= bmrs_pkg::OP_INV;
        end
        default: begin
          op_r <= bmrs_pkg::OP_NONE;
        end
      endcase
    end else if (scan_done) begin
      lo_r <= fs_nxt;
      hi_r <= ls_nxt;
      op_r <= any_set_nxt ? bmrs_pkg::OP_SET : bmrs_pkg::OP_NONE;
    end

    if (acc_clr) begin
      any_set_r <= 1'b0;
      any_clr_r <= 1'b0;
      bitv_r    <= 1'b0;
      fs_r      <= '0;
      ls_r      <= '0;
      fc_r      <= '0;
      cnt_r     <= '0;
    end else if (stg_vld_r && state_r != bmrs_pkg::ST_CLEAR) begin
      any_set_r <= any_set_nxt;
      any_clr_r <= any_clr_nxt;
      bitv_r    <= bitv_nxt;
      fs_r      <= fs_nxt;
      ls_r      <= ls_nxt;
      fc_r      <= fc_nxt;
      cnt_r     <= cnt_nxt;
    end

    if (out_load) begin
      out_r.bit_value    <= bitv_nxt;
      out_r.first_set    <= fs_nxt[bmrs_pkg::POS_W-1:0];
      out_r.first_clear  <= fc_nxt[bmrs_pkg::POS_W-1:0];
      out_r.any_clear    <= any_clr_nxt;
      out_r.last_set     <= ls_nxt[bmrs_pkg::POS_W-1:0];
      out_r.any_set      <= any_set_nxt;
      out_r.set_count    <= cnt_nxt[bmrs_pkg::SIZE_W-1:0];
      out_r.bad_position <= bad_r;
    end
  end

`ifndef SYNTHESIS
  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (state_r == bmrs_pkg::ST_IDLE))
    else $error("result strobe outside idle");

  a_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("command taken but engine not busy");

  a_stage_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == bmrs_pkg::ST_IDLE) |-> !stg_vld_r)
    else $error("sweep stage live while idle");

  a_first_last: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == bmrs_pkg::ST_UPDATE && any_set_r) |-> (fs_r <= ls_r))
    else $error("first set above last set");

  a_cfg_excl: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_take |-> !cmd_take && (state_r == bmrs_pkg::ST_IDLE))
    else $error("config write overlaps a command");
`endif

endmodule
